### rtl/core/wmps_pkg.sv
// ----------------------------------------------------------------------------
// wmps_pkg
// Types and constants shared by the window-minimum popularity scorer.
// ----------------------------------------------------------------------------
package wmps_pkg;

    localparam int MAX_CHUNK_DEF  = 16384;
    localparam int HISTO_BINS_DEF = 66;
    localparam int WIN_W          = 7;
    localparam int WIN_RESET      = 64;
    localparam int WIN_MIN        = 2;
    localparam int WIN_MAX        = 64;
    localparam int SCORE_W        = 7;
    localparam int SCORE_MAX      = 127;
    localparam int RANK_W         = 16;
    localparam int COUNT_W        = 15;
    localparam int COUNT_MAX      = 32767;
    localparam int IDX_CMP_W      = 18;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_SCORE = 2'd1;
    localparam logic [1:0] REQ_HIST  = 2'd2;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_SCORE = 2'd1;
    localparam logic [1:0] KIND_HIST  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] rank;
        logic        last;
        logic [13:0] index;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] value;
        logic        error;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_TOP,
        ST_WH_RD,
        ST_WH_CHK,
        ST_SC_ST,
        ST_SCAN,
        ST_FIN,
        ST_BP_RD,
        ST_BP_WR,
        ST_HS_RD,
        ST_HS_BIN,
        ST_HS_WR,
        ST_DONE
    } t_state;

endpackage

### rtl/core/wmps_ram.sv
// ----------------------------------------------------------------------------
// wmps_ram
// Generic one-write one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/window_min_popularity_scorer.sv
// ----------------------------------------------------------------------------
// window_min_popularity_scorer
// Scores window minima of a loaded rank chunk and keeps a score histogram.
// ----------------------------------------------------------------------------
// A load not marked last leaves the block idle; loads may run back to back.
// After reset, and again on every load marked last, the score and histogram
// memories are swept clear, one entry per cycle, over all MAX_CHUNK score
// entries while busy is high; a chunk in error then goes to the done beat.
// Scoring walks the chunk through one rank memory port: a position passing
// the slide check is carried on the slide path, else it gets a fresh window
// scan; each point is a score read-modify-write. Then a histogram pass reads,
// bins and writes each scored position, and the done beat follows. Reads go
// via registered memory data and a registered beat. Results are single-cycle
// strobed beats the receiver cannot stall; busy low means a request is taken.
// ----------------------------------------------------------------------------
module window_min_popularity_scorer
    import wmps_pkg::*;
#(
    parameter int MAX_CHUNK  = MAX_CHUNK_DEF,
    parameter int HISTO_BINS = HISTO_BINS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_strobe,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_CHUNK);
    localparam int CW = AW + 1;
    localparam int HB = $clog2(HISTO_BINS);

    t_state r_state, n_state;

    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_mp, n_mp;
    logic [RANK_W-1:0]  r_mr, n_mr;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_nw, n_nw;
    logic [WIN_W-1:0]   r_w, n_w;
    logic               r_err, n_err;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_load_cnt, n_load_cnt;
    logic               r_ovf, n_ovf;
    logic               r_init, n_init;
    logic               r_ret_wh, n_ret_wh;
    logic               r_rv, n_rv;
    logic [HB-1:0]      r_bin, n_bin;
    logic [1:0]         r_rd_kind, n_rd_kind;
    logic               r_rd_err, n_rd_err;
    logic               r_strobe, n_strobe;
    t_rsp               r_rsp, n_rsp;
    logic [WIN_W-1:0]   r_win;

    // memory ports
    logic               rank_we;
    logic [AW-1:0]      rank_waddr;
    logic [CW-1:0]      rank_rpos;
    logic [RANK_W-1:0]  rank_rdata;
    logic               score_we;
    logic [AW-1:0]      score_waddr;
    logic [SCORE_W-1:0] score_wdata;
    logic [AW-1:0]      score_raddr;
    logic [SCORE_W-1:0] score_rdata;
    logic               hist_we;
    logic [HB-1:0]      hist_waddr;
    logic [COUNT_W-1:0] hist_wdata;
    logic [HB-1:0]      hist_raddr;
    logic [COUNT_W-1:0] hist_rdata;

    logic               accept;
    logic [RANK_W-1:0]  rk;
    logic               load_room;
    logic [CW-1:0]      n_total;
    logic [WIN_W-1:0]   w_cl;
    logic [CW-1:0]      i_plus_w;
    logic               scan_last;
    logic [HB-1:0]      bin_sel;
    logic               wh_cond;
    logic               ovf_now;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign rk        = r_rv ? rank_rdata : '0;
    assign load_room = (r_load_cnt < CW'(MAX_CHUNK));
    assign n_total   = r_load_cnt + CW'(load_room);
    assign ovf_now   = r_ovf || !load_room;
    assign w_cl      = (r_win < WIN_W'(WIN_MIN)) ? WIN_W'(WIN_MIN) :
                       (r_win > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : r_win;
    assign i_plus_w  = r_i + CW'(r_w);
    assign scan_last = (r_j == i_plus_w - CW'(1));
    assign bin_sel   = (score_rdata >= SCORE_W'(HISTO_BINS - 1)) ?
                       HB'(HISTO_BINS - 1) : HB'(score_rdata);
    assign wh_cond   = (rk >= r_mr) && (r_i < r_mp) && (r_i <= r_nw);
    assign o_strobe  = r_strobe;
    assign o_rsp     = r_rsp;

    wmps_ram #(.WIDTH(RANK_W), .DEPTH(MAX_CHUNK)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (i_req.rank),
        .i_raddr (rank_rpos[AW-1:0]),
        .o_rdata (rank_rdata)
    );

    wmps_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_CHUNK)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (score_we),
        .i_waddr (score_waddr),
        .i_wdata (score_wdata),
        .i_raddr (score_raddr),
        .o_rdata (score_rdata)
    );

    wmps_ram #(.WIDTH(COUNT_W), .DEPTH(HISTO_BINS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_cnt == CW'(MAX_CHUNK - 1)) begin
                    n_state = r_init ? ST_IDLE : (r_err ? ST_DONE : ST_TOP);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        REQ_LOAD:  n_state = i_req.last ? ST_CLR : ST_IDLE;
                        REQ_SCORE: n_state = ST_RD;
                        REQ_HIST:  n_state = ST_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD:     n_state = ST_IDLE;
            ST_TOP: begin
                if (r_i >= r_nw) begin
                    n_state = ST_HS_RD;
                end else if (r_i != '0 && r_mr != '0) begin
                    n_state = ST_WH_RD;
                end else begin
                    n_state = ST_SC_ST;
                end
            end
            ST_WH_RD:  n_state = ST_WH_CHK;
            ST_WH_CHK: n_state = wh_cond ? ST_BP_RD : ST_SC_ST;
            ST_SC_ST:  n_state = ST_SCAN;
            ST_SCAN:   n_state = scan_last ? ST_FIN : ST_SCAN;
            ST_FIN:    n_state = (r_mr != '0) ? ST_BP_RD : ST_TOP;
            ST_BP_RD:  n_state = ST_BP_WR;
            ST_BP_WR:  n_state = r_ret_wh ? ST_WH_RD : ST_TOP;
            ST_HS_RD:  n_state = ST_HS_BIN;
            ST_HS_BIN: n_state = ST_HS_WR;
            ST_HS_WR:  n_state = (r_cnt + CW'(1) >= r_nw) ? ST_DONE : ST_HS_RD;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        n_i        = r_i;
        n_j        = r_j;
        n_mp       = r_mp;
        n_mr       = r_mr;
        n_n        = r_n;
        n_nw       = r_nw;
        n_w        = r_w;
        n_err      = r_err;
        n_cnt      = r_cnt;
        n_load_cnt = r_load_cnt;
        n_ovf      = r_ovf;
        n_init     = r_init;
        n_ret_wh   = r_ret_wh;
        n_bin      = r_bin;
        n_rd_kind  = r_rd_kind;
        n_rd_err   = r_rd_err;
        n_strobe   = 1'b0;
        n_rsp      = r_rsp;
        case (r_state)
            ST_CLR: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_CHUNK - 1)) begin
                    n_init = 1'b0;
                    n_i    = '0;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_rd_kind = (i_req.req_type == REQ_SCORE) ? KIND_SCORE : KIND_HIST;
                    n_rd_err  = (i_req.req_type == REQ_SCORE) ?
                                (IDX_CMP_W'(i_req.index) >= IDX_CMP_W'(MAX_CHUNK)) :
                                (IDX_CMP_W'(i_req.index) >= IDX_CMP_W'(HISTO_BINS));
                    if (i_req.req_type == REQ_LOAD) begin
                        n_load_cnt = n_total;
                        n_ovf      = ovf_now;
                        if (i_req.last) begin
                            n_n        = n_total;
                            n_w        = w_cl;
                            n_nw       = n_total - CW'(w_cl);
                            n_err      = ovf_now || (n_total <= CW'(w_cl));
                            n_load_cnt = '0;
                            n_ovf      = 1'b0;
                            n_cnt      = '0;
                        end
                    end
                end
            end
            ST_RD: begin
                n_strobe    = 1'b1;
                n_rsp.kind  = r_rd_kind;
                n_rsp.error = r_rd_err;
                if (r_rd_err) begin
                    n_rsp.value = '0;
                end else if (r_rd_kind == KIND_SCORE) begin
                    n_rsp.value = COUNT_W'(score_rdata);
                end else begin
                    n_rsp.value = hist_rdata;
                end
            end
            ST_TOP: begin
                n_cnt = '0;
            end
            ST_WH_CHK: begin
                if (wh_cond) begin
                    n_ret_wh = 1'b1;
                    if (rk == r_mr) begin
                        n_mp = i_plus_w;
                    end
                end
            end
            ST_SC_ST: begin
                n_mp = r_i;
                n_j  = r_i;
            end
            ST_SCAN: begin
                // first element seeds the minimum, tie moves only by one step
                if (r_j == r_i) begin
                    n_mr = rk;
                end else if (rk < r_mr && rk != '0) begin
                    n_mr = rk;
                    n_mp = r_j;
                end else if (r_mp == r_j - CW'(1) && rk == r_mr) begin
                    n_mp = r_j;
                end
                n_j = r_j + CW'(1);
            end
            ST_FIN: begin
                n_ret_wh = 1'b0;
                if (r_mr == '0) begin
                    n_i = r_i + CW'(1);
                end
            end
            ST_BP_WR: begin
                n_i = r_i + CW'(1);
            end
            ST_HS_BIN: begin
                n_bin = bin_sel;
            end
            ST_HS_WR: begin
                n_cnt = r_cnt + CW'(1);
            end
            ST_DONE: begin
                n_strobe    = 1'b1;
                n_rsp.kind  = KIND_DONE;
                n_rsp.error = r_err;
                n_rsp.value = r_err ? '0 : COUNT_W'(r_nw);
            end
            default: begin
            end
        endcase
    end

    // memory port drives
    always_comb begin
        rank_we     = 1'b0;
        rank_waddr  = r_load_cnt[AW-1:0];
        rank_rpos   = r_i;
        score_we    = 1'b0;
        score_waddr = r_mp[AW-1:0];
        score_wdata = '0;
        score_raddr = AW'(i_req.index);
        hist_we     = 1'b0;
        hist_waddr  = r_bin;
        hist_wdata  = '0;
        hist_raddr  = HB'(i_req.index);
        case (r_state)
            ST_CLR: begin
                score_we    = 1'b1;
                score_waddr = r_cnt[AW-1:0];
                hist_we     = (r_cnt < CW'(HISTO_BINS));
                hist_waddr  = HB'(r_cnt);
            end
            ST_IDLE: begin
                rank_we = accept && (i_req.req_type == REQ_LOAD) && load_room;
            end
            ST_WH_RD:  rank_rpos = i_plus_w;
            ST_SC_ST:  rank_rpos = r_i;
            ST_SCAN:   rank_rpos = r_j + CW'(1);
            ST_BP_RD:  score_raddr = r_mp[AW-1:0];
            ST_BP_WR: begin
                score_we    = 1'b1;
                score_wdata = (score_rdata == SCORE_W'(SCORE_MAX)) ?
                              score_rdata : score_rdata + SCORE_W'(1);
            end
            ST_HS_RD:  score_raddr = r_cnt[AW-1:0];
            ST_HS_BIN: hist_raddr = bin_sel;
            ST_HS_WR: begin
                hist_we    = 1'b1;
                hist_wdata = (hist_rdata == COUNT_W'(COUNT_MAX)) ?
                             hist_rdata : hist_rdata + COUNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // reads beyond the chunk end count as zero
    assign n_rv = (rank_rpos < r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_cnt      <= '0;
            r_load_cnt <= '0;
            r_ovf      <= 1'b0;
            r_init     <= 1'b1;
            r_strobe   <= 1'b0;
            r_win      <= WIN_W'(WIN_RESET);
            r_err      <= 1'b0;
            r_ret_wh   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_load_cnt <= n_load_cnt;
            r_ovf      <= n_ovf;
            r_init     <= n_init;
            r_strobe   <= n_strobe;
            r_err      <= n_err;
            r_ret_wh   <= n_ret_wh;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_mp      <= n_mp;
        r_mr      <= n_mr;
        r_n       <= n_n;
        r_nw      <= n_nw;
        r_w       <= n_w;
        r_rv      <= n_rv;
        r_bin     <= n_bin;
        r_rd_kind <= n_rd_kind;
        r_rd_err  <= n_rd_err;
        r_rsp     <= n_rsp;
    end

`ifndef SYNTHESIS
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_DONE || $past(r_state) == ST_RD))
        else $error("result beat without a source state");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_LOAD && i_req.last) |=>
        (r_state == ST_CLR && r_load_cnt == '0 && !r_ovf))
        else $error("last load did not start the clear sweep");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt <= CW'(MAX_CHUNK))
        else $error("load count past chunk limit");

    a_score_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BP_WR) |-> (score_wdata != '0 && score_wdata <= SCORE_W'(SCORE_MAX)))
        else $error("score write out of range");
`endif

endmodule

### test/tb_window_min_popularity_scorer.sv
// ----------------------------------------------------------------------------
// tb_window_min_popularity_scorer
// Self-checking bench for the window-minimum popularity scorer. A directed
// table covers empty reads, out-of-range bins and short chunks. Random chunks
// follow, each loaded under a fresh window size and probed with score and
// bin reads. Beats are checked against typed table rows or a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_window_min_popularity_scorer;
    import wmps_pkg::*;

    localparam int      N_ITEMS   = 1550;
    localparam int      LIMIT     = 8000000;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_op;

    typedef struct {
        t_row_op           op;
        t_req              req;
        bit                typed;
        t_rsp              rsp;
        logic [WIN_W-1:0]  win;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_strobe;
    t_rsp             o_rsp;
    logic             i_cfg_we = 1'b0;
    logic [WIN_W-1:0] i_cfg_wdata = '0;

    // predictor state
    logic [15:0]      pop_rank [MAX_CHUNK_DEF];
    logic [6:0]       pop_score [MAX_CHUNK_DEF];
    logic [14:0]      pop_hist [HISTO_BINS_DEF];
    int unsigned      pop_count;
    bit               pop_ovf;
    logic [WIN_W-1:0] pop_win;

    t_rsp             rsp_expect_q[$];
    t_row             dir_tab[$];
    int               fail_cnt = 0;
    int               items = 0;
    int               cycles = 0;
    bit               gaps_on = 1'b1;

    window_min_popularity_scorer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** window_min_popularity_scorer: FAILED **");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (rsp_expect_q.size() == 0) begin
                $error("unexpected beat kind=%0d value=%0d error=%0d",
                       o_rsp.kind, o_rsp.value, o_rsp.error);
                fail_cnt++;
            end else begin
                want = rsp_expect_q.pop_front();
                if (o_rsp.kind !== want.kind) begin
                    $error("kind: expected %0d actual %0d", want.kind, o_rsp.kind);
                    fail_cnt++;
                end
                if (o_rsp.value !== want.value) begin
                    $error("value: expected %0d actual %0d", want.value, o_rsp.value);
                    fail_cnt++;
                end
                if (o_rsp.error !== want.error) begin
                    $error("error: expected %0d actual %0d", want.error, o_rsp.error);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic logic [15:0] rank_at(int unsigned pos, int unsigned n);
        if (pos < n && pos < MAX_CHUNK_DEF)
            return pop_rank[pos];
        return 16'd0;
    endfunction

    function automatic void add_point(int unsigned pos);
        if (pos < MAX_CHUNK_DEF && pop_score[pos] < SCORE_MAX)
            pop_score[pos]++;
    endfunction

    function automatic void score_chunk(int unsigned n, int unsigned w);
        int unsigned i, j, mp, b;
        logic [15:0] mr, r;
        mp = 0;
        mr = rank_at(0, n);
        i = 0;
        while (i < n - w) begin
            // slide path: carry the old minimum while the incoming rank is not smaller
            if (i > 0 && mr > 0) begin
                while (rank_at(i + w, n) >= mr && i < mp && i < n - w + 1) begin
                    if (rank_at(i + w, n) == mr)
                        mp = i + w;
                    add_point(mp);
                    i++;
                end
            end
            mp = i;
            mr = rank_at(mp, n);
            for (j = i + 1; j < i + w; j++) begin
                r = rank_at(j, n);
                if (r < mr && r != 0) begin
                    mr = r;
                    mp = j;
                end else if (mp == j - 1 && r == mr) begin
                    mp = j;
                end
            end
            if (rank_at(mp, n) > 0)
                add_point(mp);
            i++;
        end
        for (i = 0; i < n - w && i < MAX_CHUNK_DEF; i++) begin
            b = pop_score[i];
            if (b >= HISTO_BINS_DEF)
                b = HISTO_BINS_DEF - 1;
            if (pop_hist[b] < COUNT_MAX)
                pop_hist[b]++;
        end
    endfunction

    function automatic bit predict_rsp(t_req r, output t_rsp rsp);
        int unsigned n, w;
        rsp = '0;
        case (r.req_type)
            REQ_LOAD: begin
                if (pop_count < MAX_CHUNK_DEF) begin
                    pop_rank[pop_count] = r.rank;
                    pop_count++;
                end else begin
                    pop_ovf = 1'b1;
                end
                if (!r.last)
                    return 1'b0;
                n = pop_count;
                w = (pop_win < WIN_MIN) ? WIN_MIN : (pop_win > WIN_MAX) ? WIN_MAX : pop_win;
                foreach (pop_score[k]) pop_score[k] = '0;
                foreach (pop_hist[k]) pop_hist[k] = '0;
                rsp.kind = KIND_DONE;
                if (pop_ovf || n <= w) begin
                    rsp.error = 1'b1;
                end else begin
                    score_chunk(n, w);
                    rsp.value = 15'(n - w);
                end
                pop_count = 0;
                pop_ovf = 1'b0;
                return 1'b1;
            end
            REQ_SCORE: begin
                rsp.kind = KIND_SCORE;
                rsp.value = 15'(pop_score[r.index]);
                return 1'b1;
            end
            REQ_HIST: begin
                rsp.kind = KIND_HIST;
                if (r.index < HISTO_BINS_DEF)
                    rsp.value = pop_hist[r.index];
                else
                    rsp.error = 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // one beat on the request side; start is left high for a back-to-back beat
    task automatic issue(t_req r, bit typed = 1'b0, t_rsp typed_rsp = '0);
        t_rsp rsp;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        items++;
        if (predict_rsp(r, rsp))
            rsp_expect_q.push_back(typed ? typed_rsp : rsp);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 19));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rsp_expect_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_window(logic [WIN_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pop_win = v;
    endtask

    function automatic t_req mk_req(logic [1:0] t, logic [15:0] rk, logic l, logic [13:0] ix);
        t_req r;
        r.req_type = t;
        r.rank = rk;
        r.last = l;
        r.index = ix;
        return r;
    endfunction

    function automatic void add_row(t_row_op op, t_req r, bit typed = 1'b0,
                                    t_rsp rsp = '0, logic [WIN_W-1:0] win = '0);
        t_row row;
        row.op = op;
        row.req = r;
        row.typed = typed;
        row.rsp = rsp;
        row.win = win;
        dir_tab.push_back(row);
    endfunction

    function automatic logic [15:0] rand_rank(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(0, 12));
            default: return 16'($urandom());
        endcase
    endfunction

    // load one chunk of len ranks, reads mixed in now and then
    task automatic load_chunk(int len, bit mix_reads);
        int mode;
        mode = $urandom_range(0, 2);
        for (int k = 0; k < len; k++) begin
            if (mix_reads && $urandom_range(0, 15) == 0) begin
                issue(mk_req(REQ_SCORE, 16'($urandom()), 1'b0, 14'($urandom())));
                maybe_gap();
            end
            issue(mk_req(REQ_LOAD, rand_rank(mode), 1'(k == len - 1), 14'($urandom())));
            maybe_gap();
        end
    endtask

    task automatic probe_reads(int cnt, int len);
        logic [1:0] t;
        logic [13:0] ix;
        for (int k = 0; k < cnt; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    t = REQ_SCORE;
                    ix = 14'($urandom_range(0, len));
                end
                6: begin
                    t = REQ_SCORE;
                    ix = 14'($urandom());
                end
                7: begin
                    t = REQ_HIST;
                    ix = 14'($urandom_range(0, 8));
                end
                8: begin
                    t = REQ_HIST;
                    ix = ($urandom_range(0, 1)) ? 14'($urandom()) : 14'($urandom_range(60, 67));
                end
                default: begin
                    t = REQ_NONE;
                    ix = 14'($urandom());
                end
            endcase
            issue(mk_req(t, 16'($urandom()), 1'($urandom()), ix));
            maybe_gap();
        end
    endtask

    initial begin
        t_rsp ok0;
        int w_eff, len;
        logic [WIN_W-1:0] wv;

        foreach (pop_score[k]) pop_score[k] = '0;
        foreach (pop_hist[k]) pop_hist[k] = '0;
        foreach (pop_rank[k]) pop_rank[k] = '0;
        pop_count = 0;
        pop_ovf = 1'b0;
        pop_win = WIN_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; typed rows are plain reads of cleared state or error codes
        ok0 = '0;
        add_row(ROW_REQ, mk_req(REQ_HIST, 16'h0, 1'b0, 14'd0), 1'b1, '{KIND_HIST, 15'd0, 1'b0});
        add_row(ROW_REQ, mk_req(REQ_SCORE, 16'h0, 1'b0, 14'h3FFF), 1'b1,
                '{KIND_SCORE, 15'd0, 1'b0});
        add_row(ROW_REQ, mk_req(REQ_HIST, 16'h0, 1'b0, 14'd65), 1'b1, '{KIND_HIST, 15'd0, 1'b0});
        add_row(ROW_REQ, mk_req(REQ_HIST, 16'h0, 1'b0, 14'd66), 1'b1, '{KIND_HIST, 15'd0, 1'b1});
        add_row(ROW_REQ, mk_req(REQ_HIST, 16'hFFFF, 1'b1, 14'h3FFF), 1'b1,
                '{KIND_HIST, 15'd0, 1'b1});
        add_row(ROW_REQ, mk_req(REQ_NONE, 16'hFFFF, 1'b1, 14'h3FFF));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'hFFFF, 1'b1, 14'h0), 1'b1, '{KIND_DONE, 15'd0, 1'b1});
        add_row(ROW_CFG, '0, 1'b0, ok0, 7'd0);
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'd5, 1'b0, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'd5, 1'b1, 14'h0), 1'b1, '{KIND_DONE, 15'd0, 1'b1});
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'hFFFF, 1'b0, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'd0, 1'b0, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'd3, 1'b0, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'd3, 1'b0, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'd1, 1'b0, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_LOAD, 16'hFFFF, 1'b1, 14'h0));
        add_row(ROW_REQ, mk_req(REQ_SCORE, 16'h0, 1'b0, 14'd2));
        add_row(ROW_REQ, mk_req(REQ_SCORE, 16'h0, 1'b0, 14'd3));
        add_row(ROW_REQ, mk_req(REQ_SCORE, 16'h0, 1'b0, 14'd4));
        add_row(ROW_REQ, mk_req(REQ_SCORE, 16'h0, 1'b0, 14'd6));
        add_row(ROW_REQ, mk_req(REQ_HIST, 16'h0, 1'b0, 14'd0));
        add_row(ROW_REQ, mk_req(REQ_HIST, 16'h0, 1'b0, 14'd1));
        add_row(ROW_CFG, '0, 1'b0, ok0, 7'd127);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].op == ROW_CFG)
                set_window(dir_tab[k].win);
            else
                issue(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);
        end

        // random chunks, each under a fresh window
        while (items < N_ITEMS) begin
            gaps_on = (items < N_ITEMS - 200) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0: wv = 7'($urandom_range(0, 1));
                1: wv = 7'($urandom_range(65, 127));
                2: wv = 7'd64;
                default: wv = 7'($urandom_range(2, 10));
            endcase
            set_window(wv);
            w_eff = (wv < WIN_MIN) ? WIN_MIN : (wv > WIN_MAX) ? WIN_MAX : wv;
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, w_eff);
            else
                len = w_eff + $urandom_range(1, 40);
            load_chunk(len, $urandom_range(0, 3) == 0);
            probe_reads($urandom_range(10, 40), len);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && rsp_expect_q.size() == 0)
            $display("** window_min_popularity_scorer: PASSED **");
        else
            $display("** window_min_popularity_scorer: FAILED **");
        $finish;
    end

endmodule

### window_min_popularity_scorer.f
rtl/core/wmps_pkg.sv
rtl/core/wmps_ram.sv
rtl/core/window_min_popularity_scorer.sv
test/tb_window_min_popularity_scorer.sv
